/* design/haptic_pattern_sequencer_macros.svh */
// Assertion helpers for the sequencer modules (used by hps_back).
`ifndef HAPTIC_PATTERN_SEQUENCER_MACROS_SVH
`define HAPTIC_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hps_pkg.sv */
package hps_pkg;

    typedef enum logic [3:0] {
        CMD_TICK          = 4'd0,
        CMD_CLICK         = 4'd1,
        CMD_DEFAULT_CLICK = 4'd2,
        CMD_KICK          = 4'd3,
        CMD_WIGGLE        = 4'd4,
        CMD_PURR_START    = 4'd5,
        CMD_PURR_STOP     = 4'd6,
        CMD_SERIES        = 4'd7,
        CMD_VIBRATE       = 4'd8,
        CMD_OFF           = 4'd9
    } t_cmd;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_LEVEL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_FOUR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PURR_PERIOD    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIBE_PERIOD    = 3'd6;

    localparam logic [7:0]  RST_DEFAULT_LEVEL  = 8'd2;
    localparam logic [7:0]  RST_STRENGTH_ONE   = 8'd40;
    localparam logic [7:0]  RST_STRENGTH_TWO   = 8'd80;
    localparam logic [7:0]  RST_STRENGTH_THREE = 8'd120;
    localparam logic [7:0]  RST_STRENGTH_FOUR  = 8'd200;
    localparam logic [15:0] RST_PURR_PERIOD    = 16'd150;
    localparam logic [15:0] RST_VIBE_PERIOD    = 16'd40;

    localparam logic [7:0] MS_CLICK      = 8'd30;
    localparam logic [7:0] MS_KICK       = 8'd40;
    localparam logic [7:0] MS_WIGGLE_ON  = 8'd60;
    localparam logic [7:0] MS_WIGGLE_OFF = 8'd20;
    localparam logic [7:0] MS_PURR       = 8'd20;
    localparam logic [7:0] MS_SERIES     = 8'd25;
    localparam logic [7:0] MS_VIBE       = 8'd10;
    localparam logic [7:0] MS_OFF        = 8'd0;

    localparam int VIBE_DIR_BIT = 5;

    // Wiggle is five items: on, off, on, off, on.
    localparam logic [2:0] WIGGLE_LAST_STEP = 3'd4;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] now_time;
        logic [7:0]  strength;
        logic [7:0]  level;
        logic        direction;
        logic [7:0]  pulse_count;
        logic [15:0] series_gap;
        logic [15:0] vibrate_span;
    } t_in_item;

    typedef struct packed {
        logic [7:0] phase_a;
        logic [7:0] phase_b;
        logic [7:0] phase_c;
        logic [7:0] pulse_ms;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] one;
        logic [7:0] two;
        logic [7:0] three;
        logic [7:0] four;
    } t_strengths;

    typedef struct packed {
        logic [7:0] str;
        logic       dir;
        logic [7:0] ms;
    } t_pulse;

    // One queued job: up to three pulses, or a wiggle built from slot 0.
    typedef struct packed {
        logic             wiggle;
        logic [1:0]       last_idx;
        t_pulse [2:0]     slots;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [2:0] f_clamp_level(input logic [7:0] lv);
        logic [2:0] res;
        res = (lv > 8'd4) ? 3'd3 : lv[2:0];
        return res;
    endfunction

    function automatic logic [7:0] f_level_strength(input logic [2:0] lv, input t_strengths s);
        logic [7:0] res;
        case (lv)
            3'd1:    res = s.one;
            3'd2:    res = s.two;
            3'd3:    res = s.three;
            3'd4:    res = s.four;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

    function automatic t_out_item f_pulse(input logic [7:0] s, input logic dir,
                                          input logic [7:0] ms);
        t_out_item res;
        res.phase_a  = dir ? 8'd0 : s;
        res.phase_b  = {1'b0, s[7:1]};
        res.phase_c  = dir ? s : 8'd0;
        res.pulse_ms = ms;
        res.last     = 1'b0;
        return res;
    endfunction

endpackage

/* design/haptic_pattern_sequencer.sv */
// Channel   | Handshake          | Payload / fields
// ----------+--------------------+-------------------------------------------
// command   | i_valid / o_ready  | i_cmd  (hps_pkg::t_in_item)
// pulse     | o_valid / i_ready  | o_item (hps_pkg::t_out_item)
// config    | i_cfg_wr_en        | i_cfg_index, i_cfg_data (no wait, no read)
//
// A command transaction is taken whenever the job queue has room;
// back-to-back commands enter on consecutive cycles.
// The pulse generator gives one pulse item per cycle unless i_ready stalls it;
// a command yields one item per pulse (one for click, off; up to one for kick;
// up to three for tick; five for wiggle) through the single output register.
// Reset is synchronous, active low; it restores the register defaults and
// clears all effect state. A stall on the pulse side fills the queue, after
// which o_ready drops until a job is finished.
module haptic_pattern_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  hps_pkg::t_in_item               i_cmd,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hps_pkg::t_out_item              o_item,
    input  logic                            i_cfg_wr_en,
    input  logic [hps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Front: decode each command, update purr/series/vibrate timers and
    // resolve levels to strengths, then hand a pulse job to the queue.
    logic                   push;
    hps_pkg::t_job          push_job;
    // Back: expand the job at the queue head into pulse items.
    logic                   pop;
    hps_pkg::t_job          head_job;
    hps_pkg::t_queue_status q_status;

    hps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Short job queue decouples command intake from pulse output.
    hps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // Drop each job from the queue as its final pulse enters the output register.
    hps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

/* design/hps_front.sv */
module hps_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  hps_pkg::t_in_item               i_cmd,
    input  logic                            i_cfg_wr_en,
    input  logic [hps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  hps_pkg::t_queue_status          i_q_status,
    output logic                            o_push,
    output hps_pkg::t_job                   o_job
);

    logic [7:0]          r_default_level;
    hps_pkg::t_strengths r_str;
    logic [15:0]         r_purr_period;
    logic [15:0]         r_vibe_period;

    logic        r_purr_on,    n_purr_on;
    logic [2:0]  r_purr_lvl,   n_purr_lvl;
    logic [31:0] r_purr_due,   n_purr_due;
    logic        r_purr_rev,   n_purr_rev;
    logic [7:0]  r_series_left, n_series_left;
    logic [15:0] r_series_gap, n_series_gap;
    logic [2:0]  r_series_lvl, n_series_lvl;
    logic [31:0] r_series_due, n_series_due;
    logic        r_vibe_on,    n_vibe_on;
    logic [31:0] r_vibe_end,   n_vibe_end;
    logic [2:0]  r_vibe_lvl,   n_vibe_lvl;
    logic [31:0] r_vibe_due,   n_vibe_due;

    logic          accept;
    logic          has_items;
    logic [1:0]    slot;
    logic [7:0]    mapped;
    hps_pkg::t_job job;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_items;
    assign o_job   = job;
    assign mapped  = hps_pkg::f_level_strength(hps_pkg::f_clamp_level(i_cmd.level), r_str);

    always_comb begin
        n_purr_on     = r_purr_on;
        n_purr_lvl    = r_purr_lvl;
        n_purr_due    = r_purr_due;
        n_purr_rev    = r_purr_rev;
        n_series_left = r_series_left;
        n_series_gap  = r_series_gap;
        n_series_lvl  = r_series_lvl;
        n_series_due  = r_series_due;
        n_vibe_on     = r_vibe_on;
        n_vibe_end    = r_vibe_end;
        n_vibe_lvl    = r_vibe_lvl;
        n_vibe_due    = r_vibe_due;
        job           = '0;
        has_items     = 1'b0;
        slot          = 2'd0;
        case (hps_pkg::t_cmd'(i_cmd.command))
            hps_pkg::CMD_TICK: begin
                // Pack due pulses in order purr, series, vibrate.
                if (r_purr_on && (i_cmd.now_time >= r_purr_due)) begin
                    job.slots[slot] = '{str: hps_pkg::f_level_strength(r_purr_lvl, r_str),
                                        dir: r_purr_rev, ms: hps_pkg::MS_PURR};
                    slot       = slot + 2'd1;
                    n_purr_rev = !r_purr_rev;
                    n_purr_due = i_cmd.now_time + {16'd0, r_purr_period};
                end
                if ((r_series_left != 8'd0) && (i_cmd.now_time >= r_series_due)) begin
                    job.slots[slot] = '{str: hps_pkg::f_level_strength(r_series_lvl, r_str),
                                        dir: 1'b0, ms: hps_pkg::MS_SERIES};
                    slot          = slot + 2'd1;
                    n_series_left = r_series_left - 8'd1;
                    n_series_due  = i_cmd.now_time + {16'd0, r_series_gap};
                end
                if (r_vibe_on) begin
                    if (i_cmd.now_time >= r_vibe_end) begin
                        n_vibe_on = 1'b0;
                    end else if (i_cmd.now_time >= r_vibe_due) begin
                        job.slots[slot] = '{str: hps_pkg::f_level_strength(r_vibe_lvl, r_str),
                                            dir: i_cmd.now_time[hps_pkg::VIBE_DIR_BIT],
                                            ms: hps_pkg::MS_VIBE};
                        slot       = slot + 2'd1;
                        n_vibe_due = i_cmd.now_time + {16'd0, r_vibe_period};
                    end
                end
                has_items    = (slot != 2'd0);
                job.last_idx = slot - 2'd1;
            end
            hps_pkg::CMD_CLICK: begin
                job.slots[0] = '{str: i_cmd.strength, dir: 1'b0, ms: hps_pkg::MS_CLICK};
                has_items    = 1'b1;
            end
            hps_pkg::CMD_DEFAULT_CLICK: begin
                job.slots[0] = '{str: hps_pkg::f_level_strength(
                                     hps_pkg::f_clamp_level(r_default_level), r_str),
                                 dir: 1'b0, ms: hps_pkg::MS_CLICK};
                has_items    = (r_default_level != 8'd0);
            end
            hps_pkg::CMD_KICK: begin
                job.slots[0] = '{str: mapped, dir: i_cmd.direction, ms: hps_pkg::MS_KICK};
                has_items    = (mapped != 8'd0);
            end
            hps_pkg::CMD_WIGGLE: begin
                job.wiggle   = 1'b1;
                job.slots[0] = '{str: r_str.three, dir: 1'b0, ms: hps_pkg::MS_WIGGLE_ON};
                has_items    = 1'b1;
            end
            hps_pkg::CMD_PURR_START: begin
                if (i_cmd.level != 8'd0) begin
                    n_purr_on  = 1'b1;
                    n_purr_lvl = hps_pkg::f_clamp_level(i_cmd.level);
                    n_purr_due = i_cmd.now_time;
                    n_purr_rev = 1'b0;
                end
            end
            hps_pkg::CMD_PURR_STOP: begin
                n_purr_on = 1'b0;
            end
            hps_pkg::CMD_SERIES: begin
                if ((i_cmd.level != 8'd0) && (i_cmd.pulse_count != 8'd0)) begin
                    n_series_left = i_cmd.pulse_count;
                    n_series_gap  = i_cmd.series_gap;
                    n_series_lvl  = hps_pkg::f_clamp_level(i_cmd.level);
                    n_series_due  = i_cmd.now_time;
                end
            end
            hps_pkg::CMD_VIBRATE: begin
                if ((i_cmd.level != 8'd0) && (i_cmd.vibrate_span != 16'd0)) begin
                    n_vibe_on  = 1'b1;
                    n_vibe_lvl = hps_pkg::f_clamp_level(i_cmd.level);
                    n_vibe_end = i_cmd.now_time + {16'd0, i_cmd.vibrate_span};
                    n_vibe_due = i_cmd.now_time;
                end
            end
            hps_pkg::CMD_OFF: begin
                job.slots[0] = '{str: 8'd0, dir: 1'b0, ms: hps_pkg::MS_OFF};
                has_items    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_level <= hps_pkg::RST_DEFAULT_LEVEL;
            r_str.one       <= hps_pkg::RST_STRENGTH_ONE;
            r_str.two       <= hps_pkg::RST_STRENGTH_TWO;
            r_str.three     <= hps_pkg::RST_STRENGTH_THREE;
            r_str.four      <= hps_pkg::RST_STRENGTH_FOUR;
            r_purr_period   <= hps_pkg::RST_PURR_PERIOD;
            r_vibe_period   <= hps_pkg::RST_VIBE_PERIOD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hps_pkg::CFG_DEFAULT_LEVEL:  r_default_level <= i_cfg_data[7:0];
                hps_pkg::CFG_STRENGTH_ONE:   r_str.one       <= i_cfg_data[7:0];
                hps_pkg::CFG_STRENGTH_TWO:   r_str.two       <= i_cfg_data[7:0];
                hps_pkg::CFG_STRENGTH_THREE: r_str.three     <= i_cfg_data[7:0];
                hps_pkg::CFG_STRENGTH_FOUR:  r_str.four      <= i_cfg_data[7:0];
                hps_pkg::CFG_PURR_PERIOD:    r_purr_period   <= i_cfg_data;
                hps_pkg::CFG_VIBE_PERIOD:    r_vibe_period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effect state advances on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_purr_on     <= 1'b0;
            r_purr_lvl    <= 3'd0;
            r_purr_due    <= 32'd0;
            r_purr_rev    <= 1'b0;
            r_series_left <= 8'd0;
            r_series_gap  <= 16'd0;
            r_series_lvl  <= 3'd0;
            r_series_due  <= 32'd0;
            r_vibe_on     <= 1'b0;
            r_vibe_end    <= 32'd0;
            r_vibe_lvl    <= 3'd0;
            r_vibe_due    <= 32'd0;
        end else if (accept) begin
            r_purr_on     <= n_purr_on;
            r_purr_lvl    <= n_purr_lvl;
            r_purr_due    <= n_purr_due;
            r_purr_rev    <= n_purr_rev;
            r_series_left <= n_series_left;
            r_series_gap  <= n_series_gap;
            r_series_lvl  <= n_series_lvl;
            r_series_due  <= n_series_due;
            r_vibe_on     <= n_vibe_on;
            r_vibe_end    <= n_vibe_end;
            r_vibe_lvl    <= n_vibe_lvl;
            r_vibe_due    <= n_vibe_due;
        end
    end

endmodule

/* design/hps_queue.sv */
module hps_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  hps_pkg::t_job          i_job,
    input  logic                   i_pop,
    output hps_pkg::t_job          o_job,
    output hps_pkg::t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hps_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* design/hps_back.sv */
`include "haptic_pattern_sequencer_macros.svh"

module hps_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hps_pkg::t_job          i_job,
    input  hps_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output hps_pkg::t_out_item     o_item
);

    logic [2:0]         r_step;
    logic               r_valid;
    hps_pkg::t_out_item r_item;
    hps_pkg::t_out_item item;
    hps_pkg::t_pulse    cur;
    logic               out_load;

    assign cur      = i_job.slots[r_step[1:0]];
    assign out_load = !i_q_status.empty && (!r_valid || i_ready);
    assign o_pop    = out_load && item.last;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_comb begin
        if (i_job.wiggle) begin
            // Even steps drive, odd steps rest with all phases off.
            if (r_step[0]) begin
                item = hps_pkg::f_pulse(8'd0, 1'b0, hps_pkg::MS_WIGGLE_OFF);
            end else begin
                item = hps_pkg::f_pulse(i_job.slots[0].str, r_step[1], hps_pkg::MS_WIGGLE_ON);
            end
            item.last = (r_step == hps_pkg::WIGGLE_LAST_STEP);
        end else begin
            item      = hps_pkg::f_pulse(cur.str, cur.dir, cur.ms);
            item.last = (r_step[1:0] == i_job.last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_step  <= item.last ? 3'd0 : r_step + 3'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_item <= item;
        end
    end

    `HPS_ASSERT_NOW(a_step_range, 1'b1, r_step <= hps_pkg::WIGGLE_LAST_STEP, "step out of range")
    `HPS_ASSERT_NOW(a_idle_step, i_q_status.empty, r_step == 3'd0, "step moved with no job")
    `HPS_ASSERT_NOW(a_plain_step, !i_q_status.empty && !i_job.wiggle, r_step[1:0] <= i_job.last_idx && !r_step[2], "step past job end")
    `HPS_ASSERT_NEXT(a_last_rewind, out_load && item.last, r_step == 3'd0 && r_valid && r_item.last, "job end not marked")

endmodule
